>>> rtl/core/smallest_k_index_select_unit_macros.svh
// Assertion macros shared by the smallest-k index selection unit.
`ifndef SMALLEST_K_INDEX_SELECT_UNIT_MACROS_SVH
`define SMALLEST_K_INDEX_SELECT_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high.
`define SKSEL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smallest-k unit: assertion failed");
// Next-cycle implication, disabled while reset is high.
`define SKSEL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smallest-k unit: assertion failed");
`else
`define SKSEL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SKSEL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/sksel_pkg.sv
// Shared types and constants of the smallest-k index selection unit.
package sksel_pkg;

   // Defaults of the top-level parameters.
   localparam int DEF_MAX_ELEMENTS = 64;
   localparam int DEF_VALUE_WIDTH  = 32;

   // Fixed field widths.
   localparam int INDEX_W  = 6;
   localparam int WANTED_W = 6;
   localparam int COUNT_W  = 7;

   // Queue depths between the parts.
   localparam int JOB_QUEUE_DEPTH    = 2;
   localparam int RESULT_QUEUE_DEPTH = 4;

   // Kind of a run, decided when its final word is accepted.
   localparam logic [1:0] JOB_NONE   = 2'd0;
   localparam logic [1:0] JOB_ERROR  = 2'd1;
   localparam logic [1:0] JOB_SELECT = 2'd2;

   typedef struct packed {
      logic [1:0]          kind;
      logic [COUNT_W-1:0]  n;
      logic [WANTED_W-1:0] k;
   } job_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               error;
      logic               run_end;
   } result_type;

endpackage

>>> rtl/core/sksel_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sksel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write and registered read; the read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/sksel_fifo.sv
// Small register-based first-in first-out queue.
module sksel_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/sksel_front.sv
// Front end: accepts words, stores their order keys and classifies each finished data set.
module sksel_front #(
   parameter int MAX_ELEMENTS = sksel_pkg::DEF_MAX_ELEMENTS,
   parameter int VALUE_WIDTH  = sksel_pkg::DEF_VALUE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [VALUE_WIDTH-1:0]       req_value,
   input  logic [sksel_pkg::WANTED_W-1:0]      req_wanted,
   input  logic                                req_final_item,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                job_full,
   output logic                                job_push,
   output sksel_pkg::job_type                  job_data,
   output logic                                val_wr_en,
   output logic [$clog2(MAX_ELEMENTS):0]       val_wr_addr,
   output logic [VALUE_WIDTH-1:0]              val_wr_data
);

   import sksel_pkg::*;

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             bank_ff, bank_in;
   logic             accept, room;
   logic [CNT_W-1:0] n_new;

   // A new data set may load only while a bank is free, which the job queue tracks.
   assign req_full = job_full;
   assign accept   = req_push && !job_full;
   assign room     = (count_ff < CNT_W'(MAX_ELEMENTS));
   assign n_new    = count_ff + CNT_W'(room);

   // Store the order key: flipping the sign bit makes unsigned order match signed order.
   assign val_wr_en   = accept && room;
   assign val_wr_addr = {bank_ff, count_ff[IDX_W-1:0]};
   assign val_wr_data = {~req_value[VALUE_WIDTH-1], req_value[VALUE_WIDTH-2:0]};

   // Classify the run on its final word.
   assign job_push = accept && req_final_item;
   always_comb begin
      job_data.n = COUNT_W'(n_new);
      job_data.k = req_wanted;
      if (COUNT_W'(req_wanted) >= COUNT_W'(n_new)) begin
         job_data.kind = JOB_ERROR;
      end else if (req_wanted == '0) begin
         job_data.kind = JOB_NONE;
      end else begin
         job_data.kind = JOB_SELECT;
      end
   end

   // Element count and bank select.
   always_comb begin
      count_in = count_ff;
      bank_in  = bank_ff;
      if (accept) begin
         if (req_final_item) begin
            count_in = '0;
            bank_in  = ~bank_ff;
         end else begin
            count_in = n_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bank_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         bank_ff  <= bank_in;
      end
   end

endmodule

>>> rtl/core/sksel_back.sv
// Back end: pivot search, selection scan and tie readout for one data set at a time.
`include "smallest_k_index_select_unit_macros.svh"

module sksel_back #(
   parameter int MAX_ELEMENTS = sksel_pkg::DEF_MAX_ELEMENTS,
   parameter int VALUE_WIDTH  = sksel_pkg::DEF_VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sksel_pkg::job_type            job,
   input  logic                          job_empty,
   output logic                          job_pop,
   output logic                          val_rd_en,
   output logic [$clog2(MAX_ELEMENTS):0] val_rd_addr,
   input  logic [VALUE_WIDTH-1:0]        val_rd_data,
   input  logic                          res_full,
   output logic                          res_push,
   output sksel_pkg::result_type         res_data
);

   import sksel_pkg::*;

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CAND  = 3'd1;
   localparam logic [2:0] S_CLOAD = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;
   localparam logic [2:0] S_TIE   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic                   bank_ff, bank_in;
   logic [VALUE_WIDTH-1:0] cand_ff, cand_in;
   logic [IDX_W-1:0]       pick_ff, pick_in;
   logic [IDX_W-1:0]       addr_ff, addr_in;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic                   rv_ff, rv_in;
   logic                   rl_ff, rl_in;
   logic [IDX_W-1:0]       ridx_ff, ridx_in;
   logic [CNT_W-1:0]       lt_ff, lt_in;
   logic [CNT_W-1:0]       le_ff, le_in;
   logic [CNT_W-1:0]       smaller_ff, smaller_in;
   logic [CNT_W-1:0]       ties_ff, ties_in;

   logic [COUNT_W-1:0] k_ext, need;
   logic               is_less, is_eq, hit, tie_ok;
   logic               scanning, stall, issue;
   logic [CNT_W-1:0]   lt_next, le_next, smaller_next, ties_next;
   logic               tie_wr_en, tie_rd_en;
   logic [IDX_W-1:0]   tie_rd_data;

   // Compare the word returned by the store with the current candidate or pivot.
   assign k_ext        = COUNT_W'(job.k);
   assign is_less      = (val_rd_data < cand_ff);
   assign is_eq        = (val_rd_data == cand_ff);
   assign lt_next      = lt_ff + CNT_W'(is_less);
   assign le_next      = le_ff + CNT_W'(is_less || is_eq);
   assign hit          = (COUNT_W'(lt_next) <= k_ext) && (k_ext < COUNT_W'(le_next));
   assign smaller_next = smaller_ff + CNT_W'(is_less);
   assign tie_ok       = is_eq && ((COUNT_W'(ties_ff) + COUNT_W'(smaller_ff)) < k_ext);
   assign ties_next    = ties_ff + CNT_W'(tie_ok);
   assign need         = k_ext - COUNT_W'(smaller_next);

   // Read issue: one address per cycle, held back while a result cannot be queued.
   assign scanning = (state_ff == S_SCAN) || (state_ff == S_EMIT) || (state_ff == S_TIE);
   assign stall    = rv_ff && res_full
                     && (((state_ff == S_EMIT) && is_less) || (state_ff == S_TIE));
   assign issue    = scanning && (rem_ff != '0) && !stall;

   assign val_rd_en   = (state_ff == S_CAND) || (issue && (state_ff != S_TIE));
   assign val_rd_addr = {bank_ff, (state_ff == S_CAND) ? pick_ff : addr_ff};
   assign tie_rd_en   = issue && (state_ff == S_TIE);
   assign tie_wr_en   = (state_ff == S_EMIT) && rv_ff && tie_ok && !stall;

   // Tie list: indices equal to the pivot, in ascending order.
   sksel_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_tie_ram (
      .clock   (clock),
      .wr_en   (tie_wr_en),
      .wr_addr (ties_ff[IDX_W-1:0]),
      .wr_data (ridx_ff),
      .rd_en   (tie_rd_en),
      .rd_addr (addr_ff),
      .rd_data (tie_rd_data)
   );

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      bank_in    = bank_ff;
      cand_in    = cand_ff;
      pick_in    = pick_ff;
      addr_in    = addr_ff;
      rem_in     = rem_ff;
      rv_in      = rv_ff;
      rl_in      = rl_ff;
      ridx_in    = ridx_ff;
      lt_in      = lt_ff;
      le_in      = le_ff;
      smaller_in = smaller_ff;
      ties_in    = ties_ff;
      job_pop    = 1'b0;
      res_push   = 1'b0;
      res_data   = '0;

      // Read pipeline bookkeeping.
      if (!stall) begin
         rv_in   = issue;
         rl_in   = issue && (rem_ff == CNT_W'(1));
         ridx_in = addr_ff;
      end
      if (issue) begin
         rem_in  = rem_ff - 1'b1;
         addr_in = (state_ff == S_TIE) ? addr_ff - 1'b1 : addr_ff + 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (!job_empty) begin
               unique case (job.kind)
                  JOB_ERROR: begin
                     if (!res_full) begin
                        res_push         = 1'b1;
                        res_data.error   = 1'b1;
                        res_data.run_end = 1'b1;
                        state_in         = S_DONE;
                     end
                  end
                  JOB_SELECT: begin
                     pick_in  = '0;
                     state_in = S_CAND;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_CAND: begin
            state_in = S_CLOAD;
         end
         S_CLOAD: begin
            cand_in  = val_rd_data;
            lt_in    = '0;
            le_in    = '0;
            addr_in  = '0;
            rem_in   = CNT_W'(job.n);
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (rv_ff) begin
               lt_in = lt_next;
               le_in = le_next;
               if (rl_ff) begin
                  if (hit) begin
                     smaller_in = '0;
                     ties_in    = '0;
                     addr_in    = '0;
                     rem_in     = CNT_W'(job.n);
                     state_in   = S_EMIT;
                  end else begin
                     pick_in  = pick_ff + 1'b1;
                     state_in = S_CAND;
                  end
               end
            end
         end
         S_EMIT: begin
            if (rv_ff && !stall) begin
               smaller_in = smaller_next;
               ties_in    = ties_next;
               if (is_less) begin
                  res_push         = 1'b1;
                  res_data.index   = INDEX_W'(ridx_ff);
                  res_data.run_end = (COUNT_W'(smaller_next) == k_ext);
               end
               if (rl_ff) begin
                  if (need == '0) begin
                     state_in = S_DONE;
                  end else begin
                     addr_in  = IDX_W'(ties_next - CNT_W'(1));
                     rem_in   = CNT_W'(need);
                     state_in = S_TIE;
                  end
               end
            end
         end
         S_TIE: begin
            if (rv_ff && !stall) begin
               res_push         = 1'b1;
               res_data.index   = INDEX_W'(tie_rd_data);
               res_data.run_end = rl_ff;
               if (rl_ff) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            job_pop  = 1'b1;
            bank_in  = ~bank_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bank_ff  <= 1'b0;
         rem_ff   <= '0;
         rv_ff    <= 1'b0;
         rl_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         bank_ff  <= bank_in;
         rem_ff   <= rem_in;
         rv_ff    <= rv_in;
         rl_ff    <= rl_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      cand_ff    <= cand_in;
      pick_ff    <= pick_in;
      addr_ff    <= addr_in;
      ridx_ff    <= ridx_in;
      lt_ff      <= lt_in;
      le_ff      <= le_in;
      smaller_ff <= smaller_in;
      ties_ff    <= ties_in;
   end

   `SKSEL_ASSERT_IMP(a_result_room, clock, reset, res_push, !res_full)
   `SKSEL_ASSERT_IMP(a_job_present, clock, reset, job_pop, !job_empty)
   `SKSEL_ASSERT_IMP(a_pivot_in_range, clock, reset, state_ff == S_CAND, COUNT_W'(pick_ff) < job.n)
   `SKSEL_ASSERT_IMP(a_ties_cover_need, clock, reset, state_ff == S_TIE, rem_ff <= ties_ff)
   `SKSEL_ASSERT_NEXT(a_job_pop_idle, clock, reset, job_pop, (state_ff == S_IDLE) && !rv_ff)

endmodule

>>> rtl/core/smallest_k_index_select_unit.sv
// Top level of the smallest-k index selection unit: front end, job queue, store, back end.
// Loading takes one word per cycle while full is low; a second data set loads while the
// first is selected. Selection tries candidates from index 0 until the pivot is found, reading
// all n words per candidate; a final scan emits results, then ties are read out when needed.
// The pivot search compares one stored word per cycle through the single store read port.
// Synchronous reset clears the control state; the stores need no clearing pass.
module smallest_k_index_select_unit #(
   parameter int MAX_ELEMENTS = sksel_pkg::DEF_MAX_ELEMENTS,
   parameter int VALUE_WIDTH  = sksel_pkg::DEF_VALUE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic signed [VALUE_WIDTH-1:0]  req_value,
   input  logic [sksel_pkg::WANTED_W-1:0] req_wanted,
   input  logic                           req_final_item,
   input  logic                           push,
   output logic                           full,
   output logic [sksel_pkg::INDEX_W-1:0]  rsp_index,
   output logic                           rsp_error,
   output logic                           rsp_run_end,
   output logic                           empty,
   input  logic                           pop
);

   import sksel_pkg::*;

   localparam int VAL_AW = $clog2(MAX_ELEMENTS) + 1;

   job_type                job_in_data, job_head;
   logic                   job_push, job_pop, job_empty, job_full;
   logic                   val_wr_en, val_rd_en;
   logic [VAL_AW-1:0]      val_wr_addr, val_rd_addr;
   logic [VALUE_WIDTH-1:0] val_wr_data, val_rd_data;
   result_type             res_data, res_head;
   logic                   res_push, res_full;

   // Accept and classify.
   sksel_front #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .req_wanted     (req_wanted),
      .req_final_item (req_final_item),
      .req_push       (push),
      .req_full       (full),
      .job_full       (job_full),
      .job_push       (job_push),
      .job_data       (job_in_data),
      .val_wr_en      (val_wr_en),
      .val_wr_addr    (val_wr_addr),
      .val_wr_data    (val_wr_data)
   );

   // Pending runs; an entry stays until its run is finished, which frees its bank.
   sksel_fifo #(
      .WIDTH ($bits(job_type)),
      .DEPTH (JOB_QUEUE_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .pop       (job_pop),
      .head      (job_head),
      .empty     (job_empty),
      .full      (job_full)
   );

   // Two banks of order keys.
   sksel_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (2 << $clog2(MAX_ELEMENTS))
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_en   (val_rd_en),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   // Selection engine.
   sksel_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job         (job_head),
      .job_empty   (job_empty),
      .job_pop     (job_pop),
      .val_rd_en   (val_rd_en),
      .val_rd_addr (val_rd_addr),
      .val_rd_data (val_rd_data),
      .res_full    (res_full),
      .res_push    (res_push),
      .res_data    (res_data)
   );

   // Result words wait here for the consumer.
   sksel_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RESULT_QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .pop       (pop),
      .head      (res_head),
      .empty     (empty),
      .full      (res_full)
   );

   assign rsp_index   = res_head.index;
   assign rsp_error   = res_head.error;
   assign rsp_run_end = res_head.run_end;

endmodule
